@@ rtl/tcce_pkg.sv @@
// shared constants, codes and word types of the text console cursor engine
package tcce_pkg;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int SCAN_W = $clog2(CELLS + 1);
    localparam int RPOS_W = $clog2(ROWS + 1);
    localparam int CPOS_W = $clog2(COLS);
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;

    localparam int CHAR_W = 8;
    localparam int FMT_W = 8;
    localparam int CELL_W = CHAR_W + FMT_W;
    localparam int OP_W = 2;
    localparam int ACT_W = 3;
    localparam int CROW_W = 5;
    localparam int CCOL_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAR_W-1:0] LF_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] CR_CODE = 8'd13;
    localparam logic [CHAR_W-1:0] BLANK_CODE = 8'd0;

    localparam logic [FMT_W-1:0] FORMAT_RST = 8'd7;
    localparam logic [CHAR_W-1:0] DELETE_RST = 8'd8;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR   = 2'd0,
        OP_CURSOR = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_HOME      = 3'd0,
        ACT_LINE_HOME = 3'd1,
        ACT_BACK      = 3'd2,
        ACT_FWD       = 3'd3,
        ACT_LINE_FWD  = 3'd4
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FORMAT  = 2'd0,
        REG_ADVANCE = 2'd1,
        REG_SCROLL  = 2'd2,
        REG_DELETE  = 2'd3
    } reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESULT,
        ST_READ,
        ST_WRITE,
        ST_CLEAR,
        ST_SCROLL
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [ACT_W-1:0]  cursor_action;
        logic [CROW_W-1:0] cell_row;
        logic [CCOL_W-1:0] cell_col;
    } cmd_t;

    typedef struct packed {
        logic [CROW_W-1:0] cursor_row;
        logic [CCOL_W-1:0] cursor_col;
        logic [CHAR_W-1:0] read_char;
        logic [FMT_W-1:0]  read_format;
    } result_t;

endpackage

@@ rtl/tcce_ram.sv @@
// generic simple dual-port ram with registered read
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/text_console_cursor_engine.sv @@
// Text console cursor engine: a ROWS x COLS grid of character/format cells held in one
// synchronous RAM, plus the cursor. A word is taken when start is high and busy is low;
// its result appears on result for one cycle with done high and cannot be held off.
// Characters, cursor actions and cell reads return to idle through one result or read state.
// A clear screen sweeps the RAM one cell a cycle. A cursor movement that passes the bottom
// with scrolling on copies the grid up one row through the RAM's read port and write port,
// one cell a cycle, and a delete then writes its blank at the start of the last row.
// After reset the RAM is cleared in one pass with busy high; configuration writes are
// taken at any time and should only be made while idle.
module text_console_cursor_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tcce_pkg::cmd_t                     cmd,
    output logic                               done,
    output tcce_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tcce_pkg::state_t state_reg, state_next;
    logic [tcce_pkg::RPOS_W-1:0] row_reg, row_next;
    logic [tcce_pkg::CPOS_W-1:0] col_reg, col_next;
    logic [tcce_pkg::SCAN_W-1:0] scan_reg, scan_next;
    logic init_reg, init_next;
    logic del_pend_reg, del_pend_next;
    logic rd_ok_reg, rd_ok_next;
    logic done_reg, done_next;
    tcce_pkg::result_t result_reg, result_next;

    logic [tcce_pkg::FMT_W-1:0]  fmt_reg;
    logic                        adv_reg;
    logic                        scroll_reg;
    logic [tcce_pkg::CHAR_W-1:0] delcode_reg;

    logic                         ram_we;
    logic [tcce_pkg::ADDR_W-1:0]  ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]  ram_wdata;
    logic [tcce_pkg::ADDR_W-1:0]  ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]  ram_rdata;

    // decode of the incoming word
    tcce_pkg::act_t act;
    logic mv_en, lf, del, pre_wr, post_wr, now_wr, scroll_hit, cell_ok;
    logic [tcce_pkg::RPOS_W-1:0] r1, r2, wrow;
    logic [tcce_pkg::CPOS_W-1:0] c1, c2, wcol;
    logic [tcce_pkg::ADDR_W-1:0] now_addr, cell_addr;
    logic [tcce_pkg::CELL_W-1:0] now_data;

    // sweep helpers
    logic [tcce_pkg::SCAN_W:0]   scan_ahead;
    logic [tcce_pkg::SCAN_W-1:0] scan_m1;
    logic finish, rd_sel;

    assign busy   = (state_reg != tcce_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        act    = tcce_pkg::ACT_HOME;
        mv_en  = 1'b0;
        lf     = 1'b0;
        del    = 1'b0;
        pre_wr = 1'b0;
        case (tcce_pkg::op_t'(cmd.operation))
            tcce_pkg::OP_CHAR:
            begin
                if (cmd.char_code == tcce_pkg::LF_CODE)
                begin
                    mv_en = 1'b1;
                    act   = tcce_pkg::ACT_LINE_FWD;
                    lf    = 1'b1;
                end
                else if (cmd.char_code == tcce_pkg::CR_CODE)
                begin
                    mv_en = 1'b1;
                    act   = tcce_pkg::ACT_LINE_HOME;
                end
                else if (cmd.char_code == delcode_reg)
                begin
                    mv_en = 1'b1;
                    act   = tcce_pkg::ACT_BACK;
                    del   = 1'b1;
                end
                else if (row_reg < tcce_pkg::RPOS_W'(tcce_pkg::ROWS))
                begin
                    pre_wr = 1'b1;
                    mv_en  = adv_reg;
                    act    = tcce_pkg::ACT_FWD;
                end
            end
            tcce_pkg::OP_CURSOR:
            begin
                mv_en = 1'b1;
                act   = tcce_pkg::act_t'(cmd.cursor_action);
            end
            default:
            begin
                mv_en = 1'b0;
            end
        endcase

        r1 = row_reg;
        c1 = col_reg;
        case (act)
            tcce_pkg::ACT_HOME:
            begin
                r1 = '0;
                c1 = '0;
            end
            tcce_pkg::ACT_LINE_HOME:
            begin
                c1 = '0;
            end
            tcce_pkg::ACT_BACK:
            begin
                if (col_reg == '0)
                begin
                    if (row_reg != '0)
                    begin
                        r1 = row_reg - 1'b1;
                        c1 = tcce_pkg::CPOS_W'(tcce_pkg::COLS - 1);
                    end
                end
                else
                begin
                    c1 = col_reg - 1'b1;
                end
            end
            tcce_pkg::ACT_FWD:
            begin
                if (col_reg == tcce_pkg::CPOS_W'(tcce_pkg::COLS - 1))
                begin
                    c1 = '0;
                    if (row_reg < tcce_pkg::RPOS_W'(tcce_pkg::ROWS))
                    begin
                        r1 = row_reg + 1'b1;
                    end
                end
                else
                begin
                    c1 = col_reg + 1'b1;
                end
            end
            tcce_pkg::ACT_LINE_FWD:
            begin
                if (row_reg < tcce_pkg::RPOS_W'(tcce_pkg::ROWS))
                begin
                    r1 = row_reg + 1'b1;
                end
            end
            default:
            begin
                r1 = row_reg;
            end
        endcase
        if (lf)
        begin
            c1 = '0;
        end

        // bottom check after any movement
        scroll_hit = mv_en && scroll_reg && (r1 >= tcce_pkg::RPOS_W'(tcce_pkg::ROWS));
        if (scroll_hit)
        begin
            r2 = tcce_pkg::RPOS_W'(tcce_pkg::ROWS - 1);
            c2 = '0;
        end
        else if (mv_en)
        begin
            r2 = r1;
            c2 = c1;
        end
        else
        begin
            r2 = row_reg;
            c2 = col_reg;
        end

        post_wr  = del && (r2 < tcce_pkg::RPOS_W'(tcce_pkg::ROWS));
        now_wr   = pre_wr || (post_wr && !scroll_hit);
        wrow     = pre_wr ? row_reg : r2;
        wcol     = pre_wr ? col_reg : c2;
        now_addr = tcce_pkg::ADDR_W'(tcce_pkg::ADDR_W'(wrow) * tcce_pkg::ADDR_W'(tcce_pkg::COLS))
                   + tcce_pkg::ADDR_W'(wcol);
        now_data = {fmt_reg, (pre_wr ? cmd.char_code : tcce_pkg::BLANK_CODE)};

        cell_ok   = (cmd.cell_row < tcce_pkg::ROWS) && (cmd.cell_col < tcce_pkg::COLS);
        cell_addr = cell_ok ?
                    tcce_pkg::ADDR_W'(tcce_pkg::ADDR_W'(cmd.cell_row)
                                      * tcce_pkg::ADDR_W'(tcce_pkg::COLS))
                    + tcce_pkg::ADDR_W'(cmd.cell_col) : '0;
    end

    assign scan_ahead = {1'b0, scan_reg} + (tcce_pkg::SCAN_W + 1)'(tcce_pkg::COLS);
    assign scan_m1    = scan_reg - 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        scan_next     = scan_reg;
        init_next     = init_reg;
        del_pend_next = del_pend_reg;
        rd_ok_next    = rd_ok_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = scan_reg[tcce_pkg::ADDR_W-1:0];
        ram_wdata     = '0;
        ram_raddr     = cell_addr;
        finish        = 1'b0;
        rd_sel        = 1'b0;

        case (state_reg)
            tcce_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    scan_next = '0;
                    case (tcce_pkg::op_t'(cmd.operation))
                        tcce_pkg::OP_CHAR, tcce_pkg::OP_CURSOR:
                        begin
                            row_next      = r2;
                            col_next      = c2;
                            ram_we        = now_wr;
                            ram_waddr     = now_addr;
                            ram_wdata     = now_data;
                            del_pend_next = post_wr && scroll_hit;
                            state_next    = scroll_hit ? tcce_pkg::ST_SCROLL
                                                       : tcce_pkg::ST_RESULT;
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            init_next  = 1'b0;
                            state_next = tcce_pkg::ST_CLEAR;
                        end
                        tcce_pkg::OP_READ:
                        begin
                            rd_ok_next = cell_ok;
                            state_next = tcce_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = tcce_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            tcce_pkg::ST_RESULT:
            begin
                finish = 1'b1;
            end
            tcce_pkg::ST_READ:
            begin
                finish = 1'b1;
                rd_sel = rd_ok_reg;
            end
            tcce_pkg::ST_WRITE:
            begin
                // blank left by a delete that scrolled lands at the start of the last row
                ram_we    = 1'b1;
                ram_waddr = tcce_pkg::ADDR_W'(tcce_pkg::LAST_ROW_BASE);
                ram_wdata = {fmt_reg, tcce_pkg::BLANK_CODE};
                finish    = 1'b1;
            end
            tcce_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg[tcce_pkg::ADDR_W-1:0];
                if (scan_reg == tcce_pkg::SCAN_W'(tcce_pkg::CELLS - 1))
                begin
                    scan_next = '0;
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = tcce_pkg::ST_IDLE;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            tcce_pkg::ST_SCROLL:
            begin
                // read one row ahead, write the cell read in the previous cycle
                ram_raddr = (scan_ahead < (tcce_pkg::SCAN_W + 1)'(tcce_pkg::CELLS)) ?
                            scan_ahead[tcce_pkg::ADDR_W-1:0] : '0;
                if (scan_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_m1[tcce_pkg::ADDR_W-1:0];
                    ram_wdata = (scan_m1 < tcce_pkg::SCAN_W'(tcce_pkg::LAST_ROW_BASE)) ?
                                ram_rdata : '0;
                end
                if (scan_reg == tcce_pkg::SCAN_W'(tcce_pkg::CELLS))
                begin
                    scan_next = '0;
                    if (del_pend_reg)
                    begin
                        del_pend_next = 1'b0;
                        state_next    = tcce_pkg::ST_WRITE;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = tcce_pkg::ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next              = tcce_pkg::ST_IDLE;
            done_next               = 1'b1;
            result_next.cursor_row  = tcce_pkg::CROW_W'(row_reg);
            result_next.cursor_col  = tcce_pkg::CCOL_W'(col_reg);
            result_next.read_char   = rd_sel ? ram_rdata[tcce_pkg::CHAR_W-1:0] : '0;
            result_next.read_format = rd_sel ? ram_rdata[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W]
                                             : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcce_pkg::ST_CLEAR;
            row_reg      <= '0;
            col_reg      <= '0;
            scan_reg     <= '0;
            init_reg     <= 1'b1;
            del_pend_reg <= 1'b0;
            rd_ok_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            scan_reg     <= scan_next;
            init_reg     <= init_next;
            del_pend_reg <= del_pend_next;
            rd_ok_reg    <= rd_ok_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg     <= tcce_pkg::FORMAT_RST;
            adv_reg     <= 1'b1;
            scroll_reg  <= 1'b1;
            delcode_reg <= tcce_pkg::DELETE_RST;
        end
        else if (cfg_we)
        begin
            case (tcce_pkg::reg_t'(cfg_index))
                tcce_pkg::REG_FORMAT:  fmt_reg     <= cfg_data[tcce_pkg::FMT_W-1:0];
                tcce_pkg::REG_ADVANCE: adv_reg     <= cfg_data[0];
                tcce_pkg::REG_SCROLL:  scroll_reg  <= cfg_data[0];
                tcce_pkg::REG_DELETE:  delcode_reg <= cfg_data[tcce_pkg::CHAR_W-1:0];
                default:               fmt_reg     <= fmt_reg;
            endcase
        end
    end

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a result word only goes out once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == tcce_pkg::ST_IDLE))
        else $error("result word while sequencer not idle");

    // cursor stays inside the grid, with one row past the bottom allowed
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= tcce_pkg::RPOS_W'(tcce_pkg::ROWS))
        && (col_reg <= tcce_pkg::CPOS_W'(tcce_pkg::COLS - 1)))
        else $error("cursor out of range");

    // an accepted word always makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    // scroll copy never reads and writes the same cell in one cycle
    a_scroll_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == tcce_pkg::ST_SCROLL)) |-> (ram_waddr != ram_raddr))
        else $error("scroll copy address collision");

    // no result word during the power-up clearing pass
    a_no_done_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !done_reg)
        else $error("result word during power-up clear");

endmodule
